// ===== rtl/bfsk_pkg.sv =====
// types, constants and sine table math for the byte fsk modulator
`timescale 1ns / 1ps
`default_nettype none

package bfsk_pkg;

    localparam int SAMPLE_W     = 16;
    localparam int MAG_W        = 15;
    localparam int STEP_W       = 32;
    localparam int SPB_W        = 10;
    localparam int BYTE_W       = 8;
    localparam int PEND_W       = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int SERIES_TERMS = 14;

    localparam logic [STEP_W-1:0] SPACE_STEP_RST = 32'd116869857;
    localparam logic [STEP_W-1:0] MARK_STEP_RST  = 32'd214261404;
    localparam logic [SPB_W-1:0]  SPB_RST        = 10'd441;
    localparam logic [MAG_W-1:0]  FULL_SCALE     = 15'd32767;
    localparam logic [63:0]       HALF_PI_Q62    = 64'h6487ED5110B4611A;

    // (2n)(2n+1) for the sine series terms
    localparam logic [63:0] SERIES_DENOM [SERIES_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210,
        64'd272, 64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812
    };

    typedef enum logic {
        KIND_LOAD = 1'b0,
        KIND_TICK = 1'b1
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPACE_STEP      = 2'd0,
        CFG_MARK_STEP       = 2'd1,
        CFG_SAMPLES_PER_BIT = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic valid;
        logic rejected;
        logic tone_bit;
        logic last_of_bit;
        logic last_of_byte;
    } t_seq_res;

    function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
        logic [127:0] prod;
        prod = {64'd0, a} * {64'd0, b};
        return prod[125:62];
    endfunction

    // trunc(32767 * sin(pi/2 * j / 2^qbits)), evaluated at elaboration
    function automatic logic [MAG_W-1:0] quarter_sine(input int j, input int qbits);
        logic [63:0] arg;
        logic [63:0] xv;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] acc;
        logic [63:0] scaled;
        arg  = 64'(j) << (62 - qbits);
        xv   = mul_q62(HALF_PI_Q62, arg);
        x2   = mul_q62(xv, xv);
        term = xv;
        acc  = xv;
        for (int n = 1; n <= SERIES_TERMS; n++) begin
            term = mul_q62(term, x2) / SERIES_DENOM[n-1];
            if (n[0]) begin
                acc = acc - term;
            end else begin
                acc = acc + term;
            end
        end
        scaled = mul_q62(acc, 64'(FULL_SCALE));
        return scaled[MAG_W-1:0];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/bfsk_if.sv =====
// request, result and register write channel interfaces
`timescale 1ns / 1ps
`default_nettype none

interface bfsk_in_if;
    import bfsk_pkg::*;
    logic              valid;
    logic              ready;
    logic              kind;
    logic [BYTE_W-1:0] data_byte;
    modport source (output valid, kind, data_byte, input ready);
    modport sink (input valid, kind, data_byte, output ready);
endinterface

interface bfsk_out_if;
    import bfsk_pkg::*;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;
    logic                       tone_bit;
    logic                       last_of_bit;
    logic                       last_of_byte;
    logic                       rejected;
    modport source (output valid, sample, tone_bit, last_of_bit, last_of_byte, rejected,
                    input ready);
    modport sink (input valid, sample, tone_bit, last_of_bit, last_of_byte, rejected,
                  output ready);
endinterface

interface bfsk_cfg_if;
    import bfsk_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [STEP_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/bfsk_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module bfsk_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/bfsk_fill.sv =====
// loads the quarter wave sine table into ram after reset
`timescale 1ns / 1ps
`default_nettype none

module bfsk_fill import bfsk_pkg::*; #(
    parameter int QUARTER_BITS = 8
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    output logic                    o_wr_en,
    output logic [QUARTER_BITS-1:0] o_wr_addr,
    output logic [MAG_W-1:0]        o_wr_data,
    output logic                    o_done
);

    localparam int QUARTER_SIZE = 1 << QUARTER_BITS;

    logic [MAG_W-1:0]        w_table [QUARTER_SIZE];
    logic [QUARTER_BITS-1:0] r_addr;
    logic [QUARTER_BITS-1:0] n_addr;
    logic                    r_done;
    logic                    n_done;

    for (genvar g = 0; g < QUARTER_SIZE; g++) begin : g_table
        assign w_table[g] = quarter_sine(g, QUARTER_BITS);
    end

    always_comb begin
        n_addr = r_addr;
        n_done = r_done;
        if (!r_done) begin
            n_addr = r_addr + 1'b1;
            if (r_addr == QUARTER_BITS'(QUARTER_SIZE - 1)) begin
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_done <= 1'b0;
        end else begin
            r_addr <= n_addr;
            r_done <= n_done;
        end
    end

    assign o_wr_en   = !r_done;
    assign o_wr_addr = r_addr;
    assign o_wr_data = w_table[r_addr];
    assign o_done    = r_done;

endmodule

`default_nettype wire

// ===== rtl/bfsk_seq.sv =====
// byte serializer, bit timing and phase accumulator
`timescale 1ns / 1ps
`default_nettype none

module bfsk_seq import bfsk_pkg::*; #(
    parameter int PHASE_BITS = 32,
    parameter int INDEX_BITS = 10
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  t_kind                 i_kind,
    input  logic [BYTE_W-1:0]     i_data_byte,
    input  logic [STEP_W-1:0]     i_space_step,
    input  logic [STEP_W-1:0]     i_mark_step,
    input  logic [SPB_W-1:0]      i_samples_per_bit,
    output t_seq_res              o_res,
    output logic [INDEX_BITS-1:0] o_phase_idx
);

    logic [BYTE_W-1:0]     r_shift_bits;
    logic [BYTE_W-1:0]     n_shift_bits;
    logic [PEND_W-1:0]     r_bits_pending;
    logic [PEND_W-1:0]     n_bits_pending;
    logic [SPB_W-1:0]      r_sample_in_bit;
    logic [SPB_W-1:0]      n_sample_in_bit;
    logic [PHASE_BITS-1:0] r_phase_acc;
    logic [PHASE_BITS-1:0] n_phase_acc;

    logic                  w_active;
    logic                  w_bit;
    logic                  w_tick;
    logic                  w_end_bit;
    logic [PHASE_BITS-1:0] w_step;

    assign w_active  = r_bits_pending != '0;
    assign w_bit     = r_shift_bits[BYTE_W-1];
    assign w_tick    = i_kind == KIND_TICK;
    assign w_end_bit = ({1'b0, r_sample_in_bit} + (SPB_W + 1)'(1)) >= {1'b0, i_samples_per_bit};
    assign w_step    = PHASE_BITS'(w_bit ? i_mark_step : i_space_step);

    always_comb begin
        o_res.valid        = i_accept && w_active;
        o_res.rejected     = !w_tick;
        o_res.tone_bit     = w_tick && w_bit;
        o_res.last_of_bit  = w_tick && w_end_bit;
        o_res.last_of_byte = w_tick && w_end_bit && (r_bits_pending == PEND_W'(1));
    end

    always_comb begin
        n_shift_bits    = r_shift_bits;
        n_bits_pending  = r_bits_pending;
        n_sample_in_bit = r_sample_in_bit;
        n_phase_acc     = r_phase_acc;
        if (i_accept) begin
            if (!w_tick) begin
                if (!w_active) begin
                    n_shift_bits    = i_data_byte;
                    n_bits_pending  = PEND_W'(BYTE_W);
                    n_sample_in_bit = '0;
                    n_phase_acc     = '0;
                end
            end else if (w_active) begin
                if (w_end_bit) begin
                    n_shift_bits    = {r_shift_bits[BYTE_W-2:0], 1'b0};
                    n_bits_pending  = r_bits_pending - 1'b1;
                    n_sample_in_bit = '0;
                    n_phase_acc     = '0;
                end else begin
                    n_sample_in_bit = r_sample_in_bit + 1'b1;
                    n_phase_acc     = r_phase_acc + w_step;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shift_bits    <= '0;
            r_bits_pending  <= '0;
            r_sample_in_bit <= '0;
            r_phase_acc     <= '0;
        end else begin
            r_shift_bits    <= n_shift_bits;
            r_bits_pending  <= n_bits_pending;
            r_sample_in_bit <= n_sample_in_bit;
            r_phase_acc     <= n_phase_acc;
        end
    end

    assign o_phase_idx = r_phase_acc[PHASE_BITS-1 -: INDEX_BITS];

endmodule

`default_nettype wire

// ===== rtl/byte_fsk_modulator.sv =====
// byte fsk modulator top level: registers, sine lookup pipeline, result register
// an accepted request passes the registered sine read and lookup stage, then the output register
// one request per cycle is taken while results drain; a held sine read stalls input
// after reset the quarter wave sine table ram loads its 2^(SINE_TABLE_ADDR_BITS-2) entries
// (256 at default) with no request taken; register writes are taken always
// reset is synchronous, active low, and restores register defaults and idle state
`timescale 1ns / 1ps
`default_nettype none

module byte_fsk_modulator import bfsk_pkg::*; #(
    parameter int PHASE_BITS           = 32,
    parameter int SINE_TABLE_ADDR_BITS = 10
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bfsk_in_if.sink    i_in,
    bfsk_out_if.source o_out,
    bfsk_cfg_if.sink   i_cfg
);

    localparam int QB    = SINE_TABLE_ADDR_BITS - 2;
    localparam int QSIZE = 1 << QB;

    logic [STEP_W-1:0] r_space_step;
    logic [STEP_W-1:0] r_mark_step;
    logic [SPB_W-1:0]  r_samples_per_bit;

    logic                            w_fill_we;
    logic [QB-1:0]                   w_fill_addr;
    logic [MAG_W-1:0]                w_fill_data;
    logic                            w_fill_done;
    t_seq_res                        w_res;
    logic [SINE_TABLE_ADDR_BITS-1:0] w_phase_idx;
    logic [1:0]                      w_quad;
    logic [QB-1:0]                   w_j;
    logic [QB-1:0]                   w_rd_addr;
    logic                            w_full;
    logic [MAG_W-1:0]                w_rd_data;
    logic                            w_in_accept;
    logic                            w_s1_move;
    logic [MAG_W-1:0]                w_mag;
    logic signed [SAMPLE_W-1:0]      w_mag_ext;
    logic signed [SAMPLE_W-1:0]      w_sample;

    logic                       r_s1_valid;
    t_seq_res                   r_s1_res;
    logic                       r_s1_neg;
    logic                       r_s1_full;
    logic                       r_out_valid;
    t_seq_res                   r_out_res;
    logic signed [SAMPLE_W-1:0] r_out_sample;

    // register writes
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_space_step      <= SPACE_STEP_RST;
            r_mark_step       <= MARK_STEP_RST;
            r_samples_per_bit <= SPB_RST;
        end else if (i_cfg.valid) begin
            case (t_cfg_idx'(i_cfg.index))
                CFG_SPACE_STEP:      r_space_step      <= i_cfg.data;
                CFG_MARK_STEP:       r_mark_step       <= i_cfg.data;
                CFG_SAMPLES_PER_BIT: r_samples_per_bit <= i_cfg.data[SPB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // handshake
    assign w_s1_move   = !r_out_valid || o_out.ready;
    assign i_in.ready  = w_fill_done && (!r_s1_valid || w_s1_move);
    assign w_in_accept = i_in.valid && i_in.ready;

    bfsk_fill #(
        .QUARTER_BITS(QB)
    ) u_fill (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .o_wr_en  (w_fill_we),
        .o_wr_addr(w_fill_addr),
        .o_wr_data(w_fill_data),
        .o_done   (w_fill_done)
    );

    bfsk_seq #(
        .PHASE_BITS(PHASE_BITS),
        .INDEX_BITS(SINE_TABLE_ADDR_BITS)
    ) u_seq (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (w_in_accept),
        .i_kind           (t_kind'(i_in.kind)),
        .i_data_byte      (i_in.data_byte),
        .i_space_step     (r_space_step),
        .i_mark_step      (r_mark_step),
        .i_samples_per_bit(r_samples_per_bit),
        .o_res            (w_res),
        .o_phase_idx      (w_phase_idx)
    );

    // quadrant folding
    assign w_quad    = w_phase_idx[SINE_TABLE_ADDR_BITS-1 -: 2];
    assign w_j       = w_phase_idx[QB-1:0];
    assign w_rd_addr = w_quad[0] ? (~w_j + 1'b1) : w_j;
    assign w_full    = w_quad[0] && (w_j == '0);

    bfsk_ram #(
        .WIDTH(MAG_W),
        .DEPTH(QSIZE)
    ) u_sine_ram (
        .i_clk    (i_clk),
        .i_wr_en  (w_fill_we),
        .i_wr_addr(w_fill_addr),
        .i_wr_data(w_fill_data),
        .i_rd_en  (w_in_accept),
        .i_rd_addr(w_rd_addr),
        .o_rd_data(w_rd_data)
    );

    // lookup stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!r_s1_valid || w_s1_move) begin
            r_s1_valid <= w_in_accept && w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_s1_res  <= w_res;
            r_s1_neg  <= w_quad[1];
            r_s1_full <= w_full;
        end
    end

    // sample build
    assign w_mag     = r_s1_full ? FULL_SCALE : w_rd_data;
    assign w_mag_ext = $signed({1'b0, w_mag});
    assign w_sample  = r_s1_res.rejected ? '0 : (r_s1_neg ? -w_mag_ext : w_mag_ext);

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_move) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_move && r_s1_valid) begin
            r_out_res    <= r_s1_res;
            r_out_sample <= w_sample;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.sample       = r_out_sample;
    assign o_out.tone_bit     = r_out_res.tone_bit;
    assign o_out.last_of_bit  = r_out_res.last_of_bit;
    assign o_out.last_of_byte = r_out_res.last_of_byte;
    assign o_out.rejected     = r_out_res.rejected;

    a_no_accept_during_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_fill_done |-> !w_in_accept)
        else $error("request accepted while sine table loads");

    a_no_accept_on_held_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_out_valid && !o_out.ready) |-> !w_in_accept)
        else $error("request accepted while lookup stage is held");

    a_held_lookup_keeps_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !w_s1_move) |=> $stable(w_rd_data))
        else $error("sine read data lost while lookup stage is held");

    a_rejected_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.rejected) |->
            (r_out_sample == '0 && !r_out_res.last_of_bit && !r_out_res.tone_bit))
        else $error("rejected result carries sample data");

    a_byte_end_is_bit_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_res.last_of_byte) |-> r_out_res.last_of_bit)
        else $error("last_of_byte without last_of_bit");

endmodule

`default_nettype wire
